// ----- sv/tce_pkg.sv -----
package tce_pkg;

    // Fixed field widths of the request and result items
    localparam int OP_BITS         = 2;
    localparam int WEIGHT_IN_BITS  = 16;
    localparam int CITY_BITS       = 6;
    localparam int SUM_BITS        = 22;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Defaults for the top-level parameters
    localparam int MAX_CITIES_DEFAULT  = 64;
    localparam int WEIGHT_BITS_DEFAULT = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_CITY    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_BITS-1:0]        operation;
        logic [WEIGHT_IN_BITS-1:0] weight;
        logic [CITY_BITS-1:0]      city;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] tour_cost;
        logic [SUM_BITS-1:0] best_cost;
        logic                new_best;
    } out_item_t;

    // Per-request control carried down the evaluation pipeline
    typedef struct packed {
        logic tour;
        logic restart;
        logic start;
        logic last;
        logic use_edge_a;
        logic use_edge_b;
    } tce_ctl_t;

endpackage

// ----- sv/tce_ram.sv -----
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tce_front.sv -----
module tce_front #(
    parameter int MAX_CITIES  = tce_pkg::MAX_CITIES_DEFAULT,
    parameter int WEIGHT_BITS = tce_pkg::WEIGHT_BITS_DEFAULT,
    parameter int ADDR_BITS   = 2 * $clog2(MAX_CITIES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tce_pkg::in_item_t      s_item,
    input  logic                   st2_ready,
    output logic                   rd_en,
    output logic [ADDR_BITS-1:0]   rd_addr_a,
    output logic [ADDR_BITS-1:0]   rd_addr_b,
    output logic                   wr_en,
    output logic [ADDR_BITS-1:0]   wr_addr,
    output logic [WEIGHT_BITS-1:0] wr_data,
    output logic                   st1_valid,
    output tce_pkg::tce_ctl_t      st1_ctl
);

    import tce_pkg::*;

    localparam int CB = ADDR_BITS / 2;
    localparam int PB = $clog2(MAX_CITIES + 1);
    localparam logic [PB-1:0] PTR_LIMIT = PB'(MAX_CITIES);

    // Lower-triangular address: larger index selects the row
    function automatic logic [ADDR_BITS-1:0] pair_addr(
        input logic [CITY_BITS-1:0] a,
        input logic [CITY_BITS-1:0] b
    );
        logic [CITY_BITS-1:0] hi;
        logic [CITY_BITS-1:0] lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return {CB'(hi), CB'(lo)};
    endfunction

    function automatic logic pair_in_range(
        input logic [CITY_BITS-1:0] a,
        input logic [CITY_BITS-1:0] b
    );
        return (32'(a) < 32'(MAX_CITIES)) && (32'(b) < 32'(MAX_CITIES));
    endfunction

    logic                 in_tour_reg, in_tour_next;
    logic [CITY_BITS-1:0] first_city_reg, first_city_next;
    logic [CITY_BITS-1:0] prev_city_reg, prev_city_next;
    logic [PB-1:0]        row_reg, row_next;
    logic [PB-1:0]        col_reg, col_next;
    logic                 st1_valid_reg;
    tce_ctl_t             st1_ctl_reg;

    logic                 accept;
    logic                 is_load, is_city, is_restart;
    logic [CITY_BITS-1:0] first_eff;
    tce_ctl_t             ctl;

    assign s_ready    = !st1_valid_reg || st2_ready;
    assign accept     = s_valid && s_ready;
    assign is_load    = (s_item.operation == OP_LOAD);
    assign is_city    = (s_item.operation == OP_CITY);
    assign is_restart = (s_item.operation == OP_RESTART);

    assign first_eff  = in_tour_reg ? first_city_reg : s_item.city;

    assign rd_en      = s_ready;
    assign rd_addr_a  = pair_addr(prev_city_reg, s_item.city);
    assign rd_addr_b  = pair_addr(s_item.city, first_eff);

    assign wr_data    = WEIGHT_BITS'(s_item.weight);
    assign wr_addr    = {CB'(row_reg), CB'(col_reg)};
    assign wr_en      = accept && is_load && (row_reg < PTR_LIMIT) && (col_reg < PTR_LIMIT);

    always_comb begin
        ctl.tour       = is_city;
        ctl.restart    = is_restart;
        ctl.start      = !in_tour_reg;
        ctl.last       = s_item.last;
        ctl.use_edge_a = in_tour_reg && pair_in_range(prev_city_reg, s_item.city);
        ctl.use_edge_b = s_item.last && pair_in_range(s_item.city, first_eff);
    end

    always_comb begin
        in_tour_next    = in_tour_reg;
        first_city_next = first_city_reg;
        prev_city_next  = prev_city_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        if (accept && is_city) begin
            in_tour_next    = !s_item.last;
            first_city_next = first_eff;
            prev_city_next  = s_item.city;
        end
        if (accept && is_load) begin
            if (wr_data == '0) begin
                // diagonal closes the row
                if (row_reg < PTR_LIMIT) begin
                    row_next = row_reg + PB'(1);
                end
                col_next = '0;
            end else if (col_reg < PTR_LIMIT) begin
                col_next = col_reg + PB'(1);
            end
        end
        if (accept && is_restart) begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tour_reg    <= 1'b0;
            first_city_reg <= '0;
            prev_city_reg  <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            st1_valid_reg  <= 1'b0;
        end else begin
            in_tour_reg    <= in_tour_next;
            first_city_reg <= first_city_next;
            prev_city_reg  <= prev_city_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            if (s_ready) begin
                st1_valid_reg <= accept && (is_city || is_restart);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            st1_ctl_reg <= ctl;
        end
    end

    assign st1_valid = st1_valid_reg;
    assign st1_ctl   = st1_ctl_reg;

endmodule

// ----- sv/tce_accum.sv -----
module tce_accum #(
    parameter int WEIGHT_BITS = tce_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   st1_valid,
    input  tce_pkg::tce_ctl_t      st1_ctl,
    input  logic [WEIGHT_BITS-1:0] edge_a,
    input  logic [WEIGHT_BITS-1:0] edge_b,
    output logic                   st2_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tce_pkg::out_item_t     m_result
);

    import tce_pkg::*;

    localparam int EB = WEIGHT_BITS + 1;
    localparam int WB = ((SUM_BITS > EB) ? SUM_BITS : EB) + 1;

    logic                st2_valid_reg;
    tce_ctl_t            st2_ctl_reg;
    logic [EB-1:0]       st2_edges_reg;

    logic                st3_valid_reg;
    logic                st3_restart_reg;
    logic [SUM_BITS-1:0] st3_cost_reg;

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SUM_BITS-1:0] best_reg, best_next;
    logic                m_valid_reg;
    out_item_t           m_result_reg, m_result_next;

    logic                st3_ready, out_ready, improved;
    logic [SUM_BITS-1:0] sum_base;
    logic [WB-1:0]       sum_wide;
    logic [EB-1:0]       edges_next;

    assign out_ready = !m_valid_reg || m_ready;
    assign st3_ready = !st3_valid_reg || out_ready;
    assign st2_ready = !st2_valid_reg || st3_ready;

    // Stage 2: sum of the edges this city adds
    assign edges_next = (st1_ctl.use_edge_a ? EB'(edge_a) : EB'(0))
                      + (st1_ctl.use_edge_b ? EB'(edge_b) : EB'(0));

    // Stage 3: saturating running sum
    assign sum_base = st2_ctl_reg.start ? '0 : sum_reg;
    assign sum_wide = WB'(sum_base) + WB'(st2_edges_reg);
    assign sum_next = (sum_wide > WB'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);

    // Stage 4: compare against the best and build the result
    assign improved = st3_cost_reg < best_reg;

    always_comb begin
        best_next = best_reg;
        if (out_ready && st3_valid_reg) begin
            if (st3_restart_reg) begin
                best_next = SUM_MAX;
            end else if (improved) begin
                best_next = st3_cost_reg;
            end
        end
        m_result_next.tour_cost = st3_cost_reg;
        m_result_next.best_cost = improved ? st3_cost_reg : best_reg;
        m_result_next.new_best  = improved;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            sum_reg       <= '0;
            best_reg      <= SUM_MAX;
        end else begin
            best_reg <= best_next;
            if (st2_ready) begin
                st2_valid_reg <= st1_valid;
            end
            if (st3_ready) begin
                st3_valid_reg <= st2_valid_reg
                               && ((st2_ctl_reg.tour && st2_ctl_reg.last) || st2_ctl_reg.restart);
                if (st2_valid_reg && st2_ctl_reg.tour) begin
                    sum_reg <= sum_next;
                end
            end
            if (out_ready) begin
                m_valid_reg <= st3_valid_reg && !st3_restart_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_ready) begin
            st2_ctl_reg   <= st1_ctl;
            st2_edges_reg <= edges_next;
        end
        if (st3_ready) begin
            st3_restart_reg <= st2_ctl_reg.restart;
            st3_cost_reg    <= sum_next;
        end
        if (out_ready) begin
            m_result_reg <= m_result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ----- sv/tour_cost_evaluator.sv -----
// Closed-tour cost evaluator. Load requests fill a lower-triangular distance
// matrix row by row (a zero weight is the diagonal and ends the row; writes
// past MAX_CITIES are dropped). City requests stream a tour; the request
// marked last closes the tour back to its first city and produces one result:
// the tour cost (saturating at all ones), the best cost since the last restart
// and a flag that is set when this tour is strictly below the old best.
// Restart requests clear the load pointers and the best cost. The block takes
// one request per clock cycle with no bubbles until a held result fills every
// stage; a result passes the front, edge-sum, running-sum and output registers.
// The rate is set by the weight store: every city needs two matrix reads (the
// edge from the previous city and the closing edge), served by two copies of
// the store that are written together and each read once per cycle. While a
// result waits at the output, the three internal stages keep accepting
// requests until all hold work. The weight store is not cleared after reset;
// reading an entry that was never loaded returns an undefined distance.
module tour_cost_evaluator #(
    parameter int MAX_CITIES  = tce_pkg::MAX_CITIES_DEFAULT,
    parameter int WEIGHT_BITS = tce_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tce_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tce_pkg::out_item_t m_result
);

    import tce_pkg::*;

    localparam int ADDR_BITS = 2 * $clog2(MAX_CITIES);
    localparam int DEPTH     = 1 << ADDR_BITS;

    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr_a, rd_addr_b;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [WEIGHT_BITS-1:0] edge_a, edge_b;
    logic                   st1_valid, st2_ready;
    tce_ctl_t               st1_ctl;

    // Decode requests, track load pointers and tour endpoints, issue reads
    tce_front #(
        .MAX_CITIES  (MAX_CITIES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .st2_ready (st2_ready),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .st1_valid (st1_valid),
        .st1_ctl   (st1_ctl)
    );

    // Edge from the previous city
    tce_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (edge_a)
    );

    // Closing edge back to the first city
    tce_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (edge_b)
    );

    // Add edges, accumulate, compare with the best, hold the result
    tce_accum #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st1_valid (st1_valid),
        .st1_ctl   (st1_ctl),
        .edge_a    (edge_a),
        .edge_b    (edge_b),
        .st2_ready (st2_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // The reported best never exceeds this tour's cost
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.best_cost <= m_result.tour_cost))
        else $error("best cost above tour cost");

    // A new best reports the tour cost as the best
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.new_best) |-> (m_result.best_cost == m_result.tour_cost))
        else $error("new best does not match tour cost");

    // Input stalls only when every stage is full behind a blocked result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import tce_pkg::*;

    // Bench sizes follow the block's default parameters
    localparam int NCITY = MAX_CITIES_DEFAULT;
    localparam int WBITS = WEIGHT_BITS_DEFAULT;
    localparam logic [6:0] EDGE_LIMIT = 7'(NCITY);

    // Operation code that the block must ignore
    localparam logic [OP_BITS-1:0] OP_IGNORED = 2'd3;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int SETTLE_LIMIT = 4000;
    localparam int LIMIT_NS     = 4_000_000;
    localparam int PRINT_LIMIT  = 40;

    logic      aclk     = 1'b0;
    logic      aresetn  = 1'b0;
    logic      s_valid  = 1'b0;
    logic      s_ready;
    in_item_t  s_item   = '0;
    logic      m_valid;
    logic      m_ready  = 1'b0;
    out_item_t m_result;

    tour_cost_evaluator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the block: distance store, load pointers, tour state
    // ------------------------------------------------------------------
    logic [WBITS-1:0]    dist_store  [NCITY*NCITY];
    bit                  dist_loaded [NCITY*NCITY];
    logic [6:0]          fill_row;
    logic [6:0]          fill_col;
    logic [CITY_BITS-1:0] tour_head;
    logic [CITY_BITS-1:0] tour_prev;
    bit                  touring;
    logic [SUM_BITS-1:0] path_sum;
    logic [SUM_BITS-1:0] best_sum;

    // Tour results still owed by the block, oldest first
    out_item_t cost_q[$];

    // Idling knobs shared by the sender, the receiver and the sequencer
    int send_gap_max = 8;
    int recv_gap_max = 8;
    bit hold_results = 1'b0;

    int n_requests = 0;
    int n_loads    = 0;
    int n_cities   = 0;
    int n_restarts = 0;
    int n_results  = 0;
    int n_holds    = 0;
    int n_errors   = 0;

    // Directed table: rows with typed set carry a hand-worked result
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t result;
    } dir_row_t;

    dir_row_t directed_rows [0:22] = '{
        // row 0: diagonal only; row 1: max distance; row 2: 1 and 100
        '{'{OP_LOAD,    16'h0000, 6'd63, 1'b1}, 1'b0, '0},
        '{'{OP_LOAD,    16'hFFFF, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOAD,    16'h0000, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOAD,    16'h0001, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOAD,    16'd100,  6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOAD,    16'h0000, 6'd0,  1'b0}, 1'b0, '0},
        // single-city tours: first one improves, second ties and does not; then a two-city tour
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b1}, 1'b1, '{22'd0, 22'd0, 1'b1}},
        '{'{OP_CITY,    16'h0000, 6'd1,  1'b1}, 1'b1, '{22'd0, 22'd0, 1'b0}},
        '{'{OP_CITY,    16'hFFFF, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd1,  1'b1}, 1'b1, '{22'd131070, 22'd0, 1'b0}},
        // restart drops the best cost back to all ones
        '{'{OP_RESTART, 16'hFFFF, 6'd63, 1'b1}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd1,  1'b0}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd2,  1'b1}, 1'b1, '{22'd65636, 22'd65636, 1'b1}},
        '{'{OP_IGNORED, 16'hFFFF, 6'd63, 1'b1}, 1'b0, '0},
        // load in the middle of a tour rewrites the diagonal of city 0
        '{'{OP_CITY,    16'hFFFF, 6'd2,  1'b0}, 1'b0, '0},
        '{'{OP_LOAD,    16'd7,    6'd63, 1'b1}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b1}, 1'b1, '{22'd2, 22'd2, 1'b1}},
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b1}, 1'b1, '{22'd7, 22'd2, 1'b0}},
        '{'{OP_RESTART, 16'h0000, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b1}, 1'b1, '{22'd7, 22'd7, 1'b1}},
        '{'{OP_LOAD,    16'h0000, 6'd0,  1'b0}, 1'b0, '0},
        '{'{OP_CITY,    16'h0000, 6'd0,  1'b1}, 1'b1, '{22'd0, 22'd0, 1'b1}}
    };

    // True once the store entry for the edge (a, b) has been written
    function automatic bit pair_ok(input logic [CITY_BITS-1:0] a, input logic [CITY_BITS-1:0] b);
        logic [CITY_BITS-1:0] hi;
        logic [CITY_BITS-1:0] lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return dist_loaded[{hi, lo}];
    endfunction

    // Add the edge (a, b) to a running cost, saturating at all ones.
    // Cities are six bits wide, so no edge can fall outside the matrix.
    function automatic logic [SUM_BITS-1:0] add_edge(input logic [SUM_BITS-1:0] acc,
                                                     input logic [CITY_BITS-1:0] a,
                                                     input logic [CITY_BITS-1:0] b);
        logic [CITY_BITS-1:0] hi;
        logic [CITY_BITS-1:0] lo;
        logic [SUM_BITS:0]    step;
        logic [SUM_BITS:0]    total;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        step = '0;
        step[WBITS-1:0] = dist_store[{hi, lo}];
        total = {1'b0, acc} + step;
        return (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_BITS-1:0];
    endfunction

    // Advance the shadow state by one request; return 1 when it closes a tour
    function automatic bit predict_cost(input in_item_t req, output out_item_t res);
        logic [WBITS-1:0] w;
        bit produced;
        res = '0;
        produced = 1'b0;
        w = req.weight[WBITS-1:0];
        case (req.operation)
            OP_LOAD: begin
                // drop writes past the matrix, pointers saturate at its edge
                if (fill_row < EDGE_LIMIT && fill_col < EDGE_LIMIT) begin
                    dist_store[{fill_row[5:0], fill_col[5:0]}] = w;
                    dist_loaded[{fill_row[5:0], fill_col[5:0]}] = 1'b1;
                end
                if (w == '0) begin
                    if (fill_row < EDGE_LIMIT) fill_row = fill_row + 7'd1;
                    fill_col = '0;
                end else if (fill_col < EDGE_LIMIT) begin
                    fill_col = fill_col + 7'd1;
                end
            end
            OP_RESTART: begin
                // store and any tour in progress survive a restart
                fill_row = '0;
                fill_col = '0;
                best_sum = SUM_MAX;
            end
            OP_CITY: begin
                if (!touring) begin
                    tour_head = req.city;
                    path_sum  = '0;
                    touring   = 1'b1;
                end else begin
                    path_sum = add_edge(path_sum, tour_prev, req.city);
                end
                tour_prev = req.city;
                if (req.last) begin
                    // close the loop; a tie with the best is not an improvement
                    path_sum     = add_edge(path_sum, req.city, tour_head);
                    res.new_best = (path_sum < best_sum);
                    if (res.new_best) best_sum = path_sum;
                    res.tour_cost = path_sum;
                    res.best_cost = best_sum;
                    touring  = 1'b0;
                    produced = 1'b1;
                end
            end
            default: ;
        endcase
        return produced;
    endfunction

    // Pick a city below span whose edge to a is loaded, and, if asked, whose
    // edge to b and to itself are loaded too. City 0 always qualifies, since
    // every row that ever saw a load has its column 0 written.
    function automatic logic [CITY_BITS-1:0] pick_city(input logic [CITY_BITS-1:0] a,
                                                       input bit need_b,
                                                       input logic [CITY_BITS-1:0] b,
                                                       input bit need_self,
                                                       input int span);
        int start;
        int k;
        logic [CITY_BITS-1:0] c;
        start = $urandom_range(0, span - 1);
        for (k = 0; k < span; k++) begin
            c = 6'((start + k) % span);
            if (pair_ok(a, c) && (!need_b || pair_ok(c, b)) && (!need_self || pair_ok(c, c)))
                return c;
        end
        return '0;
    endfunction

    // Nonzero distance drawn from one of several flavors
    function automatic logic [WBITS-1:0] draw_distance(input int style);
        case (style)
            1:       return 16'(65535 - $urandom_range(0, 255));
            2:       return 16'($urandom_range(1, 15));
            3:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offer one request, hold it until accepted, then update the shadow state.
    // A typed result from the directed table replaces the predicted one.
    task automatic send_request(input in_item_t req, input bit use_typed = 1'b0,
                                input out_item_t typed_res = '0);
        int gap;
        out_item_t res;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        if (predict_cost(req, res)) cost_q.push_back(use_typed ? typed_res : res);
        case (req.operation)
            OP_LOAD:    n_loads++;
            OP_CITY:    n_cities++;
            OP_RESTART: n_restarts++;
            default: ;
        endcase
        if (req.operation != OP_IGNORED) n_requests++;
    endtask

    task automatic send_load(input logic [WBITS-1:0] w);
        send_request('{OP_LOAD, w, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))});
    endtask

    task automatic send_restart();
        send_request('{OP_RESTART, 16'($urandom), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1))});
    endtask

    // Stray request between tour cities: mostly ignored codes, sometimes a
    // random load or a restart
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 4) send_load(16'($urandom));
        else if (pick == 5) send_restart();
        else send_request('{OP_IGNORED, 16'($urandom), 6'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1))});
    endtask

    // Build a closed tour over loaded edges only, then stream it with noise
    task automatic send_tour(input int len, input int span);
        logic [CITY_BITS-1:0] stops[$];
        int i;
        stops.push_back(pick_city('0, 1'b0, '0, len == 1, span));
        for (i = 1; i < len; i++)
            stops.push_back(pick_city(stops[i-1], i == len - 1, stops[0], 1'b0, span));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            send_request('{OP_CITY, 16'($urandom), stops[i], i == len - 1});
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (cost_q.size() == 0) begin
                report_mismatch("result with no tour pending");
            end else begin
                want = cost_q.pop_front();
                if (m_result.tour_cost !== want.tour_cost)
                    report_mismatch($sformatf("tour_cost got %0d want %0d",
                                              m_result.tour_cost, want.tour_cost));
                if (m_result.best_cost !== want.best_cost)
                    report_mismatch($sformatf("best_cost got %0d want %0d",
                                              m_result.best_cost, want.best_cost));
                if (m_result.new_best !== want.new_best)
                    report_mismatch($sformatf("new_best got %0b want %0b",
                                              m_result.new_best, want.new_best));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: draw a stall after every result; on request hold off long
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (hold_results) begin
                stall = LONG_HOLD;
                hold_results = 1'b0;
                n_holds++;
            end else begin
                stall = $urandom_range(0, recv_gap_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, directed table, then phases of random stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        int nc;
        int style;
        int span;
        int r;
        int c;
        int len;
        int start_count;
        int waited;

        fill_row  = '0;
        fill_col  = '0;
        tour_head = '0;
        tour_prev = '0;
        touring   = 1'b0;
        path_sum  = '0;
        best_sum  = SUM_MAX;

        // hold reset, release it once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

        // rows 0 to 2 are fully loaded by the table
        span = 3;
        start_count = n_requests;
        phase = 0;
        while (n_requests - start_count < RANDOM_ITEMS) begin
            phase++;
            send_gap_max = 8;
            recv_gap_max = 8;
            // run some phases flat out on both sides
            if (phase % 5 == 0) begin
                send_gap_max = 0;
                recv_gap_max = 0;
            end

            if (phase == 2) begin
                // walk the row pointer to the last row with bare diagonals,
                // then fill row 63 so that the top city indices get exercised
                send_restart();
                repeat (NCITY - 1) send_load('0);
                for (c = 0; c < NCITY - 1; c++) send_load(draw_distance(0));
                send_load('0);
                repeat (6) send_tour($urandom_range(1, 10), NCITY);
                // row pointer now sits past the matrix: drop these writes
                repeat (6) send_load(($urandom_range(0, 1) != 0) ? '0 : draw_distance(0));
                repeat (4) send_tour($urandom_range(1, 10), NCITY);
            end else if (phase == 4) begin
                // run row 0 past the last column, then tour the old matrix
                send_restart();
                repeat (NCITY + 6) send_load(draw_distance($urandom_range(0, 3)));
                send_load('0);
                repeat (5) send_tour($urandom_range(1, 6), span);
            end else if (phase == 6) begin
                // stall the result side long enough to back up the input
                hold_results = 1'b1;
                send_gap_max = 0;
                repeat (40) send_tour($urandom_range(1, 2), span);
            end else begin
                if ($urandom_range(0, 3) != 0) send_restart();
                nc = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 10);
                style = $urandom_range(0, 3);
                // heavy matrix with a very long tour to hit saturation
                if (phase == 3) begin
                    nc = $urandom_range(8, 12);
                    style = 1;
                end
                for (r = 0; r < nc; r++) begin
                    for (c = 0; c < r; c++) begin
                        // now and then end a row early
                        if ($urandom_range(0, 59) == 0) break;
                        send_load(draw_distance(style));
                    end
                    send_load('0);
                end
                span = nc;
                if (phase == 3) send_tour(90, span);
                repeat ($urandom_range(4, 12)) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                                      : $urandom_range(1, 8);
                    send_tour(len, span);
                end
            end

            // pause the sender until every owed result is back
            if (phase % 4 == 0 && cost_q.size() != 0) begin
                s_valid <= 1'b0;
                while (cost_q.size() != 0) @(posedge aclk);
            end
        end

        // drop valid and let the pipeline drain
        s_valid <= 1'b0;
        waited = 0;
        while (cost_q.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (cost_q.size() != 0)
            report_mismatch($sformatf("%0d tour results never arrived", cost_q.size()));

        $display("ran %0d requests: %0d loads, %0d tour cities, %0d restarts, %0d long holds",
                 n_requests, n_loads, n_cities, n_restarts, n_holds);
        $display("checked %0d tour results, %0d mismatches", n_results, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop if the handshakes ever hang
    initial begin : watchdog
        #(LIMIT_NS);
        $display("run timed out with %0d tour results owed", cost_q.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- tour_cost_evaluator.f -----
sv/tce_pkg.sv
sv/tce_ram.sv
sv/tce_front.sv
sv/tce_accum.sv
sv/tour_cost_evaluator.sv
bench/testbench.sv
